// ===== rtl/core/lcdwf_pkg.sv =====
// Shared types, codes and constants for the LCD write FIFO pacer.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package lcdwf_pkg;

    // Default depth of the entry FIFO (one slot always stays free)
    localparam int FIFO_DEPTH_DEF = 128;

    // Depth of the op queue between front and back
    localparam int OPQ_DEPTH = 2;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // Panel codes
    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
    localparam logic [7:0] ROW0_OFFSET    = 8'h00;
    localparam logic [7:0] ROW1_OFFSET    = 8'h40;
    localparam logic [7:0] ROW2_OFFSET    = 8'h14;
    localparam logic [7:0] ROW3_OFFSET    = 8'h54;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_CURSOR = 2'd3
    } kind_t;

    // Back end sequencer states
    typedef enum logic {
        BACK_IDLE  = 1'b0,
        BACK_FETCH = 1'b1
    } back_state_t;

    // Classified op handed from front to back; entry[8] is the data mark
    typedef struct packed {
        logic       is_tick;
        logic [8:0] entry;
    } op_t;

    // One result word
    typedef struct packed {
        logic       write_valid;
        logic       register_select;
        logic [7:0] bus_byte;
        logic       dropped;
        logic [6:0] fill_level;
    } result_t;

    // DDRAM row start addresses
    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        case (row)
            2'd0:    off = ROW0_OFFSET;
            2'd1:    off = ROW1_OFFSET;
            2'd2:    off = ROW2_OFFSET;
            2'd3:    off = ROW3_OFFSET;
            default: off = ROW0_OFFSET;
        endcase
        return off;
    endfunction

    // Set-address command for a cursor position, wrapped to 8 bits
    function automatic logic [7:0] cursor_cmd(input logic [1:0] row, input logic [4:0] column);
        return SET_DDRAM_ADDR + row_offset(row) + {3'b000, column};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcdwf_front.sv =====
// Front end: accepts input words and classifies them into queue ops.
// Depends on lcdwf_pkg.
`default_nettype none

module lcdwf_front
    import lcdwf_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // byte_value[7:0], row[9:8], column[14:10]
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // command[1:0]
    output logic                      q_push,
    output op_t                       q_op,
    input  wire logic                 q_full
);

    logic [7:0] byte_value;
    logic [1:0] row;
    logic [4:0] column;
    kind_t      kind;

    // Unpack fields
    assign byte_value = s_tdata[7:0];
    assign row        = s_tdata[9:8];
    assign column     = s_tdata[14:10];
    assign kind       = kind_t'(s_tuser);

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Build the entry for each kind
    always_comb
    begin
        q_op.is_tick = 1'b0;
        q_op.entry   = 9'h000;
        case (kind)
            KIND_TICK:
            begin
                q_op.is_tick = 1'b1;
            end
            KIND_CMD:
            begin
                q_op.entry = {1'b0, byte_value};
            end
            KIND_DATA:
            begin
                q_op.entry = {1'b1, byte_value};
            end
            KIND_CURSOR:
            begin
                q_op.entry = {1'b0, cursor_cmd(row, column)};
            end
            default:
            begin
                q_op.is_tick = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lcdwf_op_queue.sv =====
// Short op queue that decouples the front end from the back end.
// Depends on lcdwf_pkg.
`default_nettype none

module lcdwf_op_queue
    import lcdwf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output op_t       head_op
);

    localparam int PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

    op_t              slot_reg [OPQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(OPQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed op
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lcdwf_back.sv =====
// Back end: entry FIFO memory, pointers, wait counter and result register.
// Depends on lcdwf_pkg.
`default_nettype none

module lcdwf_back
    import lcdwf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       op_valid,
    input  wire op_t        op,
    output logic            op_pop,
    output logic            res_valid,
    input  wire logic       res_ready,
    output result_t         res
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int FW    = (CNT_W > 7) ? CNT_W : 7;

    logic [8:0]       mem [FIFO_DEPTH];
    logic [8:0]       rd_data_reg;
    logic             mem_we;

    back_state_t      state_reg, state_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [7:0]       wait_reg, wait_next;
    logic [7:0]       wait_ticks_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    logic             out_free;
    logic             is_full;
    logic [PTR_W-1:0] wp_inc, rp_inc;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entries waiting, cut to the 7-bit result field
    function automatic logic [6:0] fill_of(input logic [PTR_W-1:0] w, input logic [PTR_W-1:0] r);
        logic [CNT_W-1:0] f;
        logic [FW-1:0]    fx;
        if (w >= r)
        begin
            f = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            f = {1'b0, w} + CNT_W'(FIFO_DEPTH) - {1'b0, r};
        end
        fx = FW'(f);
        return fx[6:0];
    endfunction

    assign wp_inc    = next_slot(wp_reg);
    assign rp_inc    = next_slot(rp_reg);
    assign is_full   = (wp_inc == rp_reg);
    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                if (op_valid && out_free && op.is_tick && (wait_reg == '0)
                    && (rp_reg != wp_reg))
                begin
                    state_next = BACK_FETCH;
                end
            end
            BACK_FETCH:
            begin
                state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        op_pop         = 1'b0;
        mem_we         = 1'b0;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_pop   = 1'b1;
                    out_next = '0;
                    if (!op.is_tick)
                    begin
                        // Push, or drop when only the spare slot is left
                        if (is_full)
                        begin
                            out_next.dropped = 1'b1;
                        end
                        else
                        begin
                            mem_we  = 1'b1;
                            wp_next = wp_inc;
                        end
                        out_next.fill_level = fill_of(wp_next, rp_reg);
                        out_valid_next      = 1'b1;
                    end
                    else if (wait_reg != '0)
                    begin
                        // Count down the pending wait
                        wait_next           = wait_reg - 1'b1;
                        out_next.fill_level = fill_of(wp_reg, rp_reg);
                        out_valid_next      = 1'b1;
                    end
                    else if (rp_reg == wp_reg)
                    begin
                        // Nothing to drain
                        out_next.fill_level = fill_of(wp_reg, rp_reg);
                        out_valid_next      = 1'b1;
                    end
                end
            end
            BACK_FETCH:
            begin
                // Drain the head entry read last cycle
                rp_next                  = rp_inc;
                out_next                 = '0;
                out_next.write_valid     = 1'b1;
                out_next.register_select = rd_data_reg[8];
                out_next.bus_byte        = rd_data_reg[7:0];
                out_next.fill_level      = fill_of(wp_reg, rp_inc);
                out_valid_next           = 1'b1;
                if (!rd_data_reg[8])
                begin
                    wait_next = wait_ticks_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !res_ready;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BACK_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            wait_reg       <= '0;
            wait_ticks_reg <= 8'd1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                wait_ticks_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Entry memory: one write port, one registered read port at the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= op.entry;
        end
        rd_data_reg <= mem[rp_reg];
    end

endmodule

`default_nettype wire

// ===== rtl/core/lcd_write_fifo_pacer_unit.sv =====
// Top level of the LCD write FIFO pacer: front end, op queue and back end.
// Depends on lcdwf_pkg, lcdwf_front, lcdwf_op_queue and lcdwf_back.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser picks
//   the kind: tick, push command byte, push data byte, push cursor position.
//   Each accepted word yields exactly one result word on m_*: write strobe,
//   register select, bus byte, drop flag and the FIFO fill after the step.
//   cfg_wr_en/cfg_wr_data set the number of ticks skipped after a drained
//   command byte; write it only while the block is idle.
// Sequencing and throughput:
//   A push or a tick that writes nothing passes the op queue and then
//   the result register. A tick that drains an entry also passes the
//   registered read of the entry memory (BACK_FETCH state), and the
//   back end takes no new word while it is in BACK_FETCH. The back-end
//   sequencer sets the sustained rate: 1 word per cycle for pushes and
//   idle ticks while m_tready keeps the result register free.
// Reset:
//   Pointers, wait counter and queues clear; the wait setting returns to 1.
//   Entry memory contents are not cleared.
// Stalls:
//   When m_tready is low the result register holds; the 2-entry op queue
//   keeps accepting until full, then s_tready drops.
`default_nettype none

module lcd_write_fifo_pacer_unit
    import lcdwf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // byte_value[7:0], row[9:8], column[14:10]
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // command[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // write_valid[0], bus_byte[8:1], dropped[9],
                                                // fill_level[16:10]
    output logic [M_TUSER_W-1:0]      m_tuser   // register_select[0]
);

    logic    q_push, q_full, q_pop, q_head_valid;
    op_t     q_op, q_head_op;
    result_t res;

    lcdwf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_op     (q_op),
        .q_full   (q_full)
    );

    lcdwf_op_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    lcdwf_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op_valid    (q_head_valid),
        .op          (q_head_op),
        .op_pop      (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // Pack the result word
    assign m_tdata = {7'b0000000, res.fill_level, res.dropped, res.bus_byte, res.write_valid};
    assign m_tuser = res.register_select;

endmodule

`default_nettype wire

// ===== rtl/core/lcdwf_checker.sv =====
// Port-level checks for the LCD write FIFO pacer, bound to the top level.
// Depends on lcdwf_pkg and lcd_write_fifo_pacer_unit.
`default_nettype none

module lcdwf_port_checks
    import lcdwf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A bus write and a drop never come from the same word
    a_write_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("write and drop in one result");

    // Without a write, register select and bus byte stay low
    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tuser == '0) && (m_tdata[8:1] == 8'h00))
        else $error("bus driven without a write");

    // Keep the result channel quiet once reset has been seen
    a_no_valid_in_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind lcd_write_fifo_pacer_unit lcdwf_port_checks u_lcdwf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
